/* src/dgse_pkg.sv */
// ----------------------------------------------------------------------------
// Depth-gated Sobel edge detector: shared definitions
// Sizes, register indexes and the structures passed between the front end
// and the gradient pipeline.
// ----------------------------------------------------------------------------
package dgse_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int DEPTH_BITS = 16;

    // Field widths of the stream and of the registers.
    localparam int SAMPLE_W       = 16;
    localparam int OUT_DATA_W     = 8;
    localparam int IMAGE_WIDTH_W  = 12;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int DEPTH_W        = 16;
    localparam int MAG_THR_W      = 19;
    localparam int CFG_DATA_W     = 19;
    localparam int CFG_INDEX_W    = 3;

    // Derived widths.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SUM_W   = DEPTH_BITS + 2;
    localparam int SQ_W    = 2 * SUM_W;
    localparam int MAG_W   = SQ_W + 1;
    localparam int THR_W   = 2 * MAG_THR_W;
    localparam int CMP_W   = (MAG_W > THR_W) ? MAG_W : THR_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MIN_DEPTH    = 3'd2,
        REG_MAX_DEPTH    = 3'd3,
        REG_MIN_MAG      = 3'd4
    } cfg_reg_t;

    typedef logic [DEPTH_BITS-1:0] pixel_t;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
        logic             restart;
    } frame_cfg_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]   min_depth;
        logic [DEPTH_W-1:0]   max_depth;
        logic [MAG_THR_W-1:0] min_mag;
    } thresh_cfg_t;

    typedef struct packed {
        logic [8:0][DEPTH_BITS-1:0] px;
        logic                       flag_valid;
        logic                       centre;
        logic                       last;
    } win_item_t;

    function automatic logic [COL_W-1:0] col_last_of(input logic [IMAGE_WIDTH_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'd3)
            x = 32'd3;
        else if (x > 32'(MAX_WIDTH))
            x = 32'(MAX_WIDTH);
        return COL_W'(x - 32'd1);
    endfunction

    function automatic logic [ROW_W-1:0] row_last_of(input logic [IMAGE_HEIGHT_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'd3)
            x = 32'd3;
        else if (x > 32'(MAX_HEIGHT))
            x = 32'(MAX_HEIGHT);
        return ROW_W'(x - 32'd1);
    endfunction

endpackage

/* src/dgse_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dgse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/dgse_window.sv */
// ----------------------------------------------------------------------------
// Depth-gated Sobel edge detector: line stores and window
// Tracks the raster position, keeps the two rows above in line stores and
// assembles the 3x3 neighbourhood for each accepted transaction.
// ----------------------------------------------------------------------------
module dgse_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         in_ready,
    input  logic [dgse_pkg::SAMPLE_W-1:0] s_tdata,
    input  dgse_pkg::frame_cfg_t         cfg,
    output logic                         item_valid,
    output dgse_pkg::win_item_t          item
);

    logic                           accept;
    logic [dgse_pkg::COL_W-1:0]     col_reg;
    logic [dgse_pkg::COL_W-1:0]     col_next;
    logic [dgse_pkg::ROW_W-1:0]     row_reg;
    logic [dgse_pkg::ROW_W-1:0]     row_next;
    dgse_pkg::pixel_t               win_reg [6];
    dgse_pkg::pixel_t               sample;
    dgse_pkg::pixel_t               top;
    dgse_pkg::pixel_t               mid;

    assign accept = s_tvalid && in_ready;
    assign sample = s_tdata[dgse_pkg::DEPTH_BITS-1:0];

    // The read address runs one position ahead, so the data is ready when
    // the next pixel arrives.
    dgse_ram #(
        .WIDTH (dgse_pkg::DEPTH_BITS),
        .DEPTH (dgse_pkg::MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (mid),
        .raddr (col_next),
        .rdata (top)
    );

    dgse_ram #(
        .WIDTH (dgse_pkg::DEPTH_BITS),
        .DEPTH (dgse_pkg::MAX_WIDTH)
    ) u_lower (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (sample),
        .raddr (col_next),
        .rdata (mid)
    );

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg >= cfg.col_last)
            begin
                col_next = '0;
                row_next = (row_reg >= cfg.row_last) ? '0 : dgse_pkg::ROW_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = dgse_pkg::COL_W'(col_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= sample;
        end
    end

    always_comb
    begin
        item.px[0]      = win_reg[0];
        item.px[3]      = win_reg[1];
        item.px[6]      = win_reg[2];
        item.px[1]      = win_reg[3];
        item.px[4]      = win_reg[4];
        item.px[7]      = win_reg[5];
        item.px[2]      = top;
        item.px[5]      = mid;
        item.px[8]      = sample;
        item.flag_valid = (row_reg >= dgse_pkg::ROW_W'(1)) && (col_reg >= dgse_pkg::COL_W'(1));
        item.centre     = (row_reg >= dgse_pkg::ROW_W'(2)) && (col_reg >= dgse_pkg::COL_W'(2));
        item.last       = (row_reg >= cfg.row_last) && (col_reg >= cfg.col_last);
    end

    assign item_valid = accept;

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= cfg.col_last)
        else $error("column counter beyond the last column");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= cfg.row_last)
        else $error("row counter beyond the last row");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg.restart && (col_reg == cfg.col_last) |=> col_reg == '0)
        else $error("column counter failed to wrap at the end of a row");

endmodule

/* src/dgse_sobel.sv */
// ----------------------------------------------------------------------------
// Depth-gated Sobel edge detector: gradient pipeline
// Range gate, Sobel sums, squaring and threshold compare in four registered
// stages, the last of which drives the result channel.
// ----------------------------------------------------------------------------
module dgse_sobel (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  dgse_pkg::win_item_t            item,
    output logic                           in_ready,
    input  dgse_pkg::thresh_cfg_t          thr,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dgse_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] edge_flag
    output logic                           m_tuser,   // [0] flag_valid
    output logic                           m_tlast
);

    logic                          adv1;
    logic                          adv2;
    logic                          adv3;
    logic                          adv4;

    logic                          v1_reg;
    dgse_pkg::win_item_t           s1_reg;

    logic                          v2_reg;
    logic [dgse_pkg::SUM_W-1:0]    ax_reg;
    logic [dgse_pkg::SUM_W-1:0]    ay_reg;
    logic                          ok2_reg;
    logic                          fv2_reg;
    logic                          last2_reg;

    logic                          v3_reg;
    logic [dgse_pkg::SQ_W-1:0]     sqx_reg;
    logic [dgse_pkg::SQ_W-1:0]     sqy_reg;
    logic                          ok3_reg;
    logic                          fv3_reg;
    logic                          last3_reg;

    logic                          o_valid_reg;
    logic                          o_edge_reg;
    logic                          o_fv_reg;
    logic                          o_last_reg;

    logic [dgse_pkg::THR_W-1:0]    thr2_reg;

    logic [8:0]                    in_rng;
    logic                          ok;
    logic [dgse_pkg::SUM_W-1:0]    sum_r;
    logic [dgse_pkg::SUM_W-1:0]    sum_l;
    logic [dgse_pkg::SUM_W-1:0]    sum_b;
    logic [dgse_pkg::SUM_W-1:0]    sum_t;
    logic [dgse_pkg::SUM_W-1:0]    ax;
    logic [dgse_pkg::SUM_W-1:0]    ay;
    logic [dgse_pkg::CMP_W-1:0]    mag2;
    logic [dgse_pkg::CMP_W-1:0]    thr2;

    assign adv4     = !o_valid_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Stage 2: depth gate and absolute Sobel sums.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            in_rng[k] = (dgse_pkg::DEPTH_W'(s1_reg.px[k]) >= thr.min_depth)
                     && (dgse_pkg::DEPTH_W'(s1_reg.px[k]) <= thr.max_depth);
        end
        ok    = &in_rng;
        sum_r = dgse_pkg::SUM_W'(s1_reg.px[2]) + (dgse_pkg::SUM_W'(s1_reg.px[5]) << 1)
              + dgse_pkg::SUM_W'(s1_reg.px[8]);
        sum_l = dgse_pkg::SUM_W'(s1_reg.px[0]) + (dgse_pkg::SUM_W'(s1_reg.px[3]) << 1)
              + dgse_pkg::SUM_W'(s1_reg.px[6]);
        sum_b = dgse_pkg::SUM_W'(s1_reg.px[6]) + (dgse_pkg::SUM_W'(s1_reg.px[7]) << 1)
              + dgse_pkg::SUM_W'(s1_reg.px[8]);
        sum_t = dgse_pkg::SUM_W'(s1_reg.px[0]) + (dgse_pkg::SUM_W'(s1_reg.px[1]) << 1)
              + dgse_pkg::SUM_W'(s1_reg.px[2]);
        ax    = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
        ay    = (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
    end

    assign mag2 = dgse_pkg::CMP_W'(dgse_pkg::MAG_W'(sqx_reg) + dgse_pkg::MAG_W'(sqy_reg));
    assign thr2 = dgse_pkg::CMP_W'(thr2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= item_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                o_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr2_reg <= dgse_pkg::THR_W'(thr.min_mag) * dgse_pkg::THR_W'(thr.min_mag);
        if (adv1 && item_valid)
        begin
            s1_reg <= item;
        end
        if (adv2 && v1_reg)
        begin
            ax_reg    <= ax;
            ay_reg    <= ay;
            ok2_reg   <= ok && s1_reg.centre;
            fv2_reg   <= s1_reg.flag_valid;
            last2_reg <= s1_reg.last;
        end
        if (adv3 && v2_reg)
        begin
            sqx_reg   <= dgse_pkg::SQ_W'(ax_reg) * dgse_pkg::SQ_W'(ax_reg);
            sqy_reg   <= dgse_pkg::SQ_W'(ay_reg) * dgse_pkg::SQ_W'(ay_reg);
            ok3_reg   <= ok2_reg;
            fv3_reg   <= fv2_reg;
            last3_reg <= last2_reg;
        end
        if (adv4 && v3_reg)
        begin
            o_edge_reg <= ok3_reg && (mag2 > thr2);
            o_fv_reg   <= fv3_reg;
            o_last_reg <= last3_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(dgse_pkg::OUT_DATA_W-1){1'b0}}, o_edge_reg};
    assign m_tuser  = o_fv_reg;
    assign m_tlast  = o_last_reg;

    a_edge_needs_centre: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_edge_reg |-> o_fv_reg)
        else $error("edge flagged on a result without a centre pixel");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && o_valid_reg && !m_tready)
        else $error("input held off while the pipeline has a free slot");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && adv4 |=> o_valid_reg)
        else $error("result lost between the square stage and the output");

endmodule

/* src/depth_gated_sobel_edge_detect.sv */
// ----------------------------------------------------------------------------
// Depth-gated Sobel edge detector
// Marks depth edges in a raster stream of depth pixels with a 3x3 Sobel
// gradient, gated by a depth window and a magnitude threshold.
// ----------------------------------------------------------------------------
// Usage:
// Depth pixels enter on s_tdata in raster order, frame after frame. Each
// transaction yields one result transaction on the m_ side, which flags the
// pixel one row up and one column left; m_tuser is low while that pixel does
// not exist yet, and m_tlast marks the result of the last pixel of a frame.
// The block takes one pixel per cycle while s_tready is high. Each result
// passes through the four pipeline registers in turn: input window, Sobel
// sums, squares and the threshold compare in the output register.
// The two line stores are read one column ahead, so a pixel finds its upper
// neighbours already registered at the RAM outputs.
// When the receiver stalls, the result stays in the output register and
// the pipeline keeps taking pixels until all four stages are full; then
// s_tready falls. Reset clears the raster position, empties the pipeline and
// loads a 640 by 480 image, the full depth range and a zero threshold.
// Writing the image width or height restarts the frame at its first pixel.
// ----------------------------------------------------------------------------
module depth_gated_sobel_edge_detect (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dgse_pkg::SAMPLE_W-1:0]    s_tdata,    // [15:0] depth_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dgse_pkg::OUT_DATA_W-1:0]  m_tdata,    // [0] edge_flag
    output logic                             m_tuser,    // [0] flag_valid
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [dgse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dgse_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [dgse_pkg::COL_W-1:0]     col_last_reg;
    logic [dgse_pkg::ROW_W-1:0]     row_last_reg;
    logic [dgse_pkg::DEPTH_W-1:0]   min_depth_reg;
    logic [dgse_pkg::DEPTH_W-1:0]   max_depth_reg;
    logic [dgse_pkg::MAG_THR_W-1:0] min_mag_reg;
    logic                           restart;
    dgse_pkg::frame_cfg_t           frame_cfg;
    dgse_pkg::thresh_cfg_t          thresh_cfg;
    logic                           item_valid;
    dgse_pkg::win_item_t            item;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (dgse_pkg::cfg_reg_t'(cfg_index))
                dgse_pkg::REG_IMAGE_WIDTH,
                dgse_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
                default:                    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg  <= dgse_pkg::COL_W'(639);
            row_last_reg  <= dgse_pkg::ROW_W'(479);
            min_depth_reg <= '0;
            max_depth_reg <= '1;
            min_mag_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (dgse_pkg::cfg_reg_t'(cfg_index))
                dgse_pkg::REG_IMAGE_WIDTH:
                    col_last_reg <= dgse_pkg::col_last_of(
                        cfg_data[dgse_pkg::IMAGE_WIDTH_W-1:0]);
                dgse_pkg::REG_IMAGE_HEIGHT:
                    row_last_reg <= dgse_pkg::row_last_of(
                        cfg_data[dgse_pkg::IMAGE_HEIGHT_W-1:0]);
                dgse_pkg::REG_MIN_DEPTH:
                    min_depth_reg <= cfg_data[dgse_pkg::DEPTH_W-1:0];
                dgse_pkg::REG_MAX_DEPTH:
                    max_depth_reg <= cfg_data[dgse_pkg::DEPTH_W-1:0];
                dgse_pkg::REG_MIN_MAG:
                    min_mag_reg <= cfg_data[dgse_pkg::MAG_THR_W-1:0];
                default:
                    min_mag_reg <= min_mag_reg;
            endcase
        end
    end

    assign frame_cfg.col_last   = col_last_reg;
    assign frame_cfg.row_last   = row_last_reg;
    assign frame_cfg.restart    = restart;
    assign thresh_cfg.min_depth = min_depth_reg;
    assign thresh_cfg.max_depth = max_depth_reg;
    assign thresh_cfg.min_mag   = min_mag_reg;

    dgse_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .in_ready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (frame_cfg),
        .item_valid (item_valid),
        .item       (item)
    );

    dgse_sobel u_sobel (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .in_ready   (s_tready),
        .thr        (thresh_cfg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
